### hw/rtl/bson_key_search_scanner_core_defines.svh
// Assertion macros shared by the key scanner RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef BSON_KEY_SEARCH_SCANNER_CORE_DEFINES_SVH
`define BSON_KEY_SEARCH_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BKSC_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bksc check failed");
`define BKSC_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bksc check failed");
`else
`define BKSC_ASSERT_IMP(label, ck, rn, ante, cons)
`define BKSC_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

### hw/rtl/bksc_pkg.sv
// Types, constants and BSON size functions for the key scanner.
// No dependencies; imported by every module of the block.
package bksc_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int OFFSET_BITS   = 24;
    localparam int CFG_W         = 64;
    localparam int OUT_DATA_W    = 120;

    typedef enum logic [3:0] {
        PH_IDLE, PH_DOC_LEN, PH_ELEM_START, PH_SKIP, PH_NAME,
        PH_VAL_LEN, PH_REGEX1, PH_REGEX2, PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND, ST_NOT_FOUND, ST_SENTINEL, ST_OVERRUN
    } status_t;

    typedef enum logic [1:0] {
        CLS_FIXED, CLS_LEN, CLS_REGEX
    } vclass_t;

    typedef enum logic [1:0] {
        REG_KEY_LOW, REG_KEY_HIGH, REG_KEY_LEN, REG_REGION_LEN
    } reg_idx_t;

    typedef struct packed {
        status_t                  status;
        logic [OFFSET_BITS-1:0]   doc_offset;
        logic [OFFSET_BITS-1:0]   element_offset;
        logic [7:0]               element_type;
        logic [OFFSET_BITS-1:0]   value_offset;
        logic [31:0]              element_length;
    } result_t;

    function automatic vclass_t value_class(input logic [7:0] t);
        unique case (t)
            8'h02, 8'h03, 8'h04, 8'h05, 8'h0C, 8'h0D, 8'h0E, 8'h0F: return CLS_LEN;
            8'h0B:   return CLS_REGEX;
            default: return CLS_FIXED;
        endcase
    endfunction

    function automatic logic [4:0] fixed_size(input logic [7:0] t);
        unique case (t)
            8'h01, 8'h09, 8'h11, 8'h12: return 5'd8;
            8'h07:   return 5'd12;
            8'h08:   return 5'd1;
            8'h10:   return 5'd4;
            8'h13:   return 5'd16;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [35:0] len_size(input logic [7:0] t, input logic [31:0] n);
        unique case (t)
            8'h02, 8'h0D, 8'h0E: return 36'd4 + {4'b0, n};
            8'h05:   return 36'd5 + {4'b0, n};
            8'h0C:   return 36'd16 + {4'b0, n};
            default: return {4'b0, n};
        endcase
    endfunction

endpackage

### hw/rtl/bksc_parser.sv
// Byte parser: configuration, parse state and one-byte next-state logic.
// Depends on bksc_pkg and the assertion macro header.
`include "bson_key_search_scanner_core_defines.svh"
module bksc_parser
    import bksc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             step_en,
    input  logic [7:0]       data_byte,
    input  logic             region_start,
    output logic             res_valid,
    output result_t          res
);

    typedef struct packed {
        phase_t      phase;
        logic [23:0] sr;
        logic [31:0] ml;
    } fin_t;

    logic [63:0]  key_low_reg, key_high_reg;
    logic [4:0]   key_len_reg;
    logic [24:0]  region_len_reg;

    phase_t       phase_reg, phase_next;
    logic [23:0]  byte_off_reg, byte_off_next;
    logic [23:0]  doc_start_reg, doc_start_next;
    logic [23:0]  doc_end_reg, doc_end_next;
    logic [23:0]  elem_start_reg, elem_start_next;
    logic [24:0]  val_start_reg, val_start_next;
    logic [7:0]   cur_type_reg, cur_type_next;
    logic [4:0]   name_idx_reg, name_idx_next;
    logic         name_mis_reg, name_mis_next;
    logic [31:0]  len_gather_reg, len_gather_next;
    logic [23:0]  skip_rem_reg, skip_rem_next;
    logic [1:0]   zcount_reg, zcount_next;
    logic         match_pend_reg, match_pend_next;
    logic [31:0]  match_len_reg, match_len_next;

    logic [24:0]  region_eff;
    logic [4:0]   key_len_eff;
    logic [127:0] key_all;
    status_t      res_status;
    logic         done, go;
    logic [23:0]  o;
    logic [25:0]  q;
    logic [31:0]  lenv;
    logic [24:0]  hdr;
    fin_t         f;

    function automatic fin_t finish_elem(input logic [35:0] elen, input logic mp,
                                         input logic [23:0] es, input logic [23:0] ofs,
                                         input logic [23:0] de, input logic [23:0] sr_in,
                                         input logic [31:0] ml_in);
        fin_t        r;
        logic [35:0] nxt;
        r.phase = PH_TAIL;
        r.sr    = sr_in;
        r.ml    = ml_in;
        nxt     = {12'b0, es} + elen;
        if (mp)
        begin
            r.ml = (elen > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : elen[31:0];
        end
        else if (nxt >= {12'b0, de} || nxt <= {12'b0, ofs})
        begin
            r.phase = PH_TAIL;
        end
        else if (nxt == {12'b0, ofs} + 36'd1)
        begin
            r.phase = PH_ELEM_START;
        end
        else
        begin
            r.phase = PH_SKIP;
            r.sr    = 24'(nxt - {12'b0, ofs} - 36'd1);
        end
        return r;
    endfunction

    assign region_eff  = region_len_reg[24] ? 25'h100_0000 : region_len_reg;
    assign key_len_eff = (key_len_reg > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : key_len_reg;
    assign key_all     = {key_high_reg, key_low_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        byte_off_next   = byte_off_reg;
        doc_start_next  = doc_start_reg;
        doc_end_next    = doc_end_reg;
        elem_start_next = elem_start_reg;
        val_start_next  = val_start_reg;
        cur_type_next   = cur_type_reg;
        name_idx_next   = name_idx_reg;
        name_mis_next   = name_mis_reg;
        len_gather_next = len_gather_reg;
        skip_rem_next   = skip_rem_reg;
        zcount_next     = zcount_reg;
        match_pend_next = match_pend_reg;
        match_len_next  = match_len_reg;
        res_valid       = 1'b0;
        res_status      = ST_FOUND;
        done            = 1'b0;
        go              = 1'b1;
        o               = byte_off_reg;
        q               = '0;
        lenv            = '0;
        hdr             = '0;
        f               = '{phase: PH_TAIL, sr: '0, ml: '0};
        if (step_en)
        begin
            if (region_start)
            begin
                byte_off_next   = '0;
                elem_start_next = '0;
                val_start_next  = '0;
                cur_type_next   = '0;
                name_idx_next   = '0;
                name_mis_next   = 1'b0;
                skip_rem_next   = '0;
                match_len_next  = '0;
                doc_end_next    = '0;
                if (25'd4 >= region_eff)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res_status = ST_NOT_FOUND;
                    done       = 1'b1;
                end
                else
                begin
                    doc_start_next  = '0;
                    zcount_next     = '0;
                    len_gather_next = '0;
                    match_pend_next = 1'b0;
                    phase_next      = PH_DOC_LEN;
                end
            end
            if (!done && phase_next != PH_IDLE)
            begin
                o             = byte_off_next;
                byte_off_next = o + 24'd1;
                if (phase_next == PH_DOC_LEN)
                begin
                    len_gather_next = len_gather_next
                                    | ({24'b0, data_byte} << {zcount_next, 3'b000});
                    if (zcount_next != 2'd3)
                    begin
                        zcount_next = zcount_next + 2'd1;
                    end
                    else
                    begin
                        lenv = len_gather_next;
                        if (lenv == 32'd0 || lenv == 32'hFFFF_FFFF)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_status = ST_SENTINEL;
                        end
                        else if ({9'b0, doc_start_next} + {1'b0, lenv} > {8'b0, region_eff})
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_status = ST_OVERRUN;
                        end
                        else if (lenv < 32'd5)
                        begin
                            q = {2'b0, doc_start_next} + {23'b0, lenv[2:0]};
                            if (q + 26'd4 >= {1'b0, region_eff})
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                doc_start_next  = q[23:0];
                                zcount_next     = 2'(3'd4 - lenv[2:0]);
                                len_gather_next = '0;
                                match_pend_next = 1'b0;
                                phase_next      = PH_DOC_LEN;
                            end
                        end
                        else
                        begin
                            doc_end_next    = 24'(doc_start_next + lenv[23:0] - 24'd1);
                            match_pend_next = 1'b0;
                            phase_next      = PH_ELEM_START;
                        end
                    end
                end
                else
                begin
                    if (phase_next == PH_SKIP)
                    begin
                        if (skip_rem_next != 24'd0)
                        begin
                            skip_rem_next = skip_rem_next - 24'd1;
                            go            = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_ELEM_START;
                        end
                    end
                    if (go)
                    begin
                        unique case (phase_next)
                            PH_ELEM_START:
                            begin
                                if (o >= doc_end_next || data_byte == 8'h00)
                                begin
                                    phase_next = PH_TAIL;
                                end
                                else
                                begin
                                    cur_type_next   = data_byte;
                                    elem_start_next = o;
                                    name_idx_next   = '0;
                                    name_mis_next   = 1'b0;
                                    phase_next      = PH_NAME;
                                end
                            end
                            PH_NAME:
                            begin
                                if (data_byte == 8'h00 || o == doc_end_next)
                                begin
                                    if (!name_mis_next && name_idx_next == key_len_eff)
                                    begin
                                        match_pend_next = 1'b1;
                                    end
                                    val_start_next = {1'b0, o} + 25'd1;
                                    unique case (value_class(cur_type_next))
                                        CLS_LEN:
                                        begin
                                            len_gather_next = '0;
                                            zcount_next     = '0;
                                            phase_next      = PH_VAL_LEN;
                                        end
                                        CLS_REGEX:
                                        begin
                                            phase_next = PH_REGEX1;
                                        end
                                        default:
                                        begin
                                            hdr = val_start_next - {1'b0, elem_start_next};
                                            f = finish_elem({11'b0, hdr}
                                                    + {31'b0, fixed_size(cur_type_next)},
                                                    match_pend_next, elem_start_next, o,
                                                    doc_end_next, skip_rem_next,
                                                    match_len_next);
                                            phase_next     = f.phase;
                                            skip_rem_next  = f.sr;
                                            match_len_next = f.ml;
                                        end
                                    endcase
                                end
                                else if (name_idx_next < key_len_eff
                                         && data_byte == key_all[{name_idx_next[3:0], 3'b000} +: 8])
                                begin
                                    name_idx_next = name_idx_next + 5'd1;
                                end
                                else
                                begin
                                    name_mis_next = 1'b1;
                                end
                            end
                            PH_VAL_LEN:
                            begin
                                len_gather_next = len_gather_next
                                    | ({24'b0, data_byte} << {zcount_next, 3'b000});
                                if (zcount_next == 2'd3)
                                begin
                                    hdr = val_start_next - {1'b0, elem_start_next};
                                    f = finish_elem({11'b0, hdr}
                                            + len_size(cur_type_next, len_gather_next),
                                            match_pend_next, elem_start_next, o,
                                            doc_end_next, skip_rem_next, match_len_next);
                                    phase_next     = f.phase;
                                    skip_rem_next  = f.sr;
                                    match_len_next = f.ml;
                                end
                                else
                                begin
                                    zcount_next = zcount_next + 2'd1;
                                end
                            end
                            PH_REGEX1:
                            begin
                                if (data_byte == 8'h00 || o == doc_end_next)
                                begin
                                    phase_next = PH_REGEX2;
                                end
                            end
                            PH_REGEX2:
                            begin
                                if (data_byte == 8'h00 || o == doc_end_next)
                                begin
                                    f = finish_elem({12'b0, o} + 36'd1 - {12'b0, elem_start_next},
                                            match_pend_next, elem_start_next, o,
                                            doc_end_next, skip_rem_next, match_len_next);
                                    phase_next     = f.phase;
                                    skip_rem_next  = f.sr;
                                    match_len_next = f.ml;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_next;
                            end
                        endcase
                    end
                    if (o == doc_end_next)
                    begin
                        if (match_pend_next)
                        begin
                            hdr = val_start_next - {1'b0, elem_start_next};
                            if (phase_next == PH_VAL_LEN)
                            begin
                                f = finish_elem({11'b0, hdr}
                                        + len_size(cur_type_next, len_gather_next), 1'b1,
                                        elem_start_next, o, doc_end_next, skip_rem_next,
                                        match_len_next);
                                match_len_next = f.ml;
                                phase_next = PH_TAIL;
                            end
                            else if (phase_next == PH_REGEX1)
                            begin
                                f = finish_elem({11'b0, hdr} + 36'd2, 1'b1,
                                        elem_start_next, o, doc_end_next, skip_rem_next,
                                        match_len_next);
                                match_len_next = f.ml;
                                phase_next = PH_TAIL;
                            end
                            else if (phase_next == PH_REGEX2)
                            begin
                                f = finish_elem({12'b0, doc_end_next} + 36'd2
                                        - {12'b0, elem_start_next}, 1'b1,
                                        elem_start_next, o, doc_end_next, skip_rem_next,
                                        match_len_next);
                                match_len_next = f.ml;
                                phase_next = PH_TAIL;
                            end
                        end
                        if (data_byte == 8'h00 && match_pend_next)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_status = ST_FOUND;
                        end
                        else
                        begin
                            q = {2'b0, o} + 26'd1;
                            if (q + 26'd4 >= {1'b0, region_eff})
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                doc_start_next  = q[23:0];
                                zcount_next     = '0;
                                len_gather_next = '0;
                                match_pend_next = 1'b0;
                                phase_next      = PH_DOC_LEN;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        res = '0;
        res.status = res_status;
        if (res_status == ST_FOUND)
        begin
            res.doc_offset     = doc_start_next;
            res.element_offset = elem_start_next;
            res.element_type   = cur_type_next;
            res.value_offset   = val_start_next[24] ? 24'hFF_FFFF : val_start_next[23:0];
            res.element_length = match_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_len_reg    <= '0;
            region_len_reg <= 25'd5;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_KEY_LOW:    key_low_reg    <= cfg_wr_data;
                REG_KEY_HIGH:   key_high_reg   <= cfg_wr_data;
                REG_KEY_LEN:    key_len_reg    <= cfg_wr_data[4:0];
                REG_REGION_LEN: region_len_reg <= cfg_wr_data[24:0];
                default:        key_len_reg    <= key_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_off_reg   <= '0;
            doc_start_reg  <= '0;
            doc_end_reg    <= '0;
            elem_start_reg <= '0;
            val_start_reg  <= '0;
            cur_type_reg   <= '0;
            name_idx_reg   <= '0;
            name_mis_reg   <= 1'b0;
            len_gather_reg <= '0;
            skip_rem_reg   <= '0;
            zcount_reg     <= '0;
            match_pend_reg <= 1'b0;
            match_len_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_off_reg   <= byte_off_next;
            doc_start_reg  <= doc_start_next;
            doc_end_reg    <= doc_end_next;
            elem_start_reg <= elem_start_next;
            val_start_reg  <= val_start_next;
            cur_type_reg   <= cur_type_next;
            name_idx_reg   <= name_idx_next;
            name_mis_reg   <= name_mis_next;
            len_gather_reg <= len_gather_next;
            skip_rem_reg   <= skip_rem_next;
            zcount_reg     <= zcount_next;
            match_pend_reg <= match_pend_next;
            match_len_reg  <= match_len_next;
        end
    end

    `BKSC_ASSERT_NXT(a_idle_after_result, clk, rst_n, res_valid, phase_reg == PH_IDLE)
    `BKSC_ASSERT_IMP(a_name_idx_bound, clk, rst_n, 1'b1, name_idx_reg <= 5'(MAX_KEY_BYTES))

endmodule

### hw/rtl/bksc_outq.sv
// Two-entry result queue: output register plus skid entry.
// Depends on bksc_pkg and the assertion macro header.
`include "bson_key_search_scanner_core_defines.svh"
module bksc_outq
    import bksc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    head_valid,
    output result_t head_data,
    input  logic    head_ready
);

    logic    head_v_reg, skid_v_reg;
    result_t head_reg, skid_reg;
    logic    pop;

    assign pop        = head_v_reg && head_ready;
    assign full       = skid_v_reg;
    assign head_valid = head_v_reg;
    assign head_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop && push)
        begin
            head_v_reg <= 1'b1;
        end
        else if (pop)
        begin
            head_v_reg <= skid_v_reg;
            skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            if (head_v_reg)
            begin
                skid_v_reg <= 1'b1;
            end
            head_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && push)
        begin
            head_reg <= push_data;
        end
        else if (pop)
        begin
            head_reg <= skid_reg;
        end
        else if (push)
        begin
            if (head_v_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                head_reg <= push_data;
            end
        end
    end

    `BKSC_ASSERT_IMP(a_skid_needs_head, clk, rst_n, skid_v_reg, head_v_reg)
    `BKSC_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, !skid_v_reg)

endmodule

### hw/rtl/bson_key_search_scanner_core.sv
// A result is registered in the output queue, whose head entry drives m_axis.
// Throughput: one byte per cycle (single-pass byte logic) unless the queue is full.
// The output register plus one skid entry keep input flowing while a result waits.
// Reset (rst_n low, asynchronous) clears all state but queue data; the parser
// waits for region_start. Registers reset to key 0, key length 0, region length 5.
module bson_key_search_scanner_core
    import bksc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // data_byte
    input  logic                  s_axis_tuser,   // region_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // status, doc_offset, element_offset,
                                                  // element_type, value_offset,
                                                  // element_length, zero pad
);

    logic    step_en, res_valid, q_full;
    result_t res, head;

    assign s_axis_tready = !q_full;
    assign step_en       = s_axis_tvalid && s_axis_tready;

    bksc_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .step_en      (step_en),
        .data_byte    (s_axis_tdata),
        .region_start (s_axis_tuser),
        .res_valid    (res_valid),
        .res          (res)
    );

    bksc_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .full       (q_full),
        .head_valid (m_axis_tvalid),
        .head_data  (head),
        .head_ready (m_axis_tready)
    );

    assign m_axis_tdata = {6'b0, head.element_length, head.value_offset, head.element_type,
                           head.element_offset, head.doc_offset, head.status};

endmodule
